// ----- design/ilbc_pkg.sv -----
// shared types and constants for the ip literal blocklist classifier
`timescale 1ns / 1ps
`default_nettype none
package ilbc_pkg;
  localparam int unsigned MaxTextLength = 45;
  localparam int unsigned CntW = 6;
  localparam int unsigned QDepth = 2;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_V4   = 2'd1,
    KIND_V6   = 2'd2
  } kind_e;

  localparam logic [4:0] CodeNone  = 5'd0;
  localparam logic [4:0] CodeV6Base = 5'd10;
  localparam logic [4:0] CodeNotIp = 5'd16;

  // snapshot of the parser at the final character
  typedef struct packed {
    logic [7:0][15:0] head;
    logic [7:0][15:0] tail;
    logic [3:0]       head_cnt;
    logic [3:0]       tail_cnt;
    logic             dcolon;
    logic             v6_ok;
    logic             v4_ok;
    logic [31:0]      v4_addr;
    logic             colon_present;
  } parse_t;

  typedef struct packed {
    logic [1:0]  literal_kind;
    logic        blocked;
    logic [4:0]  range_code;
    logic [63:0] address_high;
    logic [63:0] address_low;
  } result_t;

  function automatic logic [4:0] match_v4(input logic [31:0] a);
    logic [4:0] r;
    r = CodeNone;
    if (a[31:24] == 8'd0) r = 5'd1;
    else if (a[31:24] == 8'd10) r = 5'd2;
    else if (a[31:22] == 10'b0110010001) r = 5'd3;
    else if (a[31:24] == 8'd127) r = 5'd4;
    else if (a[31:16] == 16'ha9fe) r = 5'd5;
    else if (a[31:20] == 12'hac1) r = 5'd6;
    else if (a[31:16] == 16'hc0a8) r = 5'd7;
    else if (a[31:28] == 4'he) r = 5'd8;
    else if (a[31:28] == 4'hf) r = 5'd9;
    return r;
  endfunction

  function automatic logic [4:0] match_v6(input logic [63:0] hi, input logic [63:0] lo);
    logic [4:0] r;
    r = CodeNone;
    if (hi == 64'd0 && lo == 64'd0) r = CodeV6Base;
    else if (hi == 64'd0 && lo == 64'd1) r = CodeV6Base + 5'd1;
    else if (hi == 64'h0064ff9b00000000 && lo[63:32] == 32'd0) r = CodeV6Base + 5'd2;
    else if (hi[63:48] == 16'h2002) r = CodeV6Base + 5'd3;
    else if (hi[63:57] == 7'b1111110) r = CodeV6Base + 5'd4;
    else if (hi[63:54] == 10'b1111111010) r = CodeV6Base + 5'd5;
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- design/ilbc_if.sv -----
// valid/ready channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface ilbc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       last_char;
  modport source (output valid, text_char, last_char, input ready);
  modport sink (input valid, text_char, last_char, output ready);
endinterface

interface ilbc_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  literal_kind;
  logic        blocked;
  logic [4:0]  range_code;
  logic [63:0] address_high;
  logic [63:0] address_low;
  modport source (output valid, literal_kind, blocked, range_code, address_high,
                  address_low, input ready);
  modport sink (input valid, literal_kind, blocked, range_code, address_high,
                address_low, output ready);
endinterface
`default_nettype wire

// ----- design/ilbc_front.sv -----
// character parser: accumulates ipv4 and ipv6 state, emits a snapshot on last char
`timescale 1ns / 1ps
`default_nettype none
module ilbc_front import ilbc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] text_char_i,
  input  wire logic       last_char_i,
  output logic            snap_valid_o,
  input  wire logic       snap_ready_i,
  output parse_t          snap_o
);
  logic [CntW-1:0] cnt_q, cnt_d;
  logic zone_q, zone_d, colp_q, colp_d, v4v_q, v4v_d;
  logic [9:0] dacc_q, dacc_d;
  logic [1:0] dcnt_q, dcnt_d;
  logic [3:0][7:0] oct_q, oct_d;
  logic [1:0] oidx_q, oidx_d;
  logic [15:0] hacc_q, hacc_d;
  logic [2:0] hcnt_q, hcnt_d;
  logic sdot_q, sdot_d;
  logic [7:0][15:0] head_q, head_d, tail_q, tail_d;
  logic [3:0] headc_q, headc_d, tailc_q, tailc_d;
  logic dcol_q, dcol_d;
  logic [1:0] crun_q, crun_d;
  logic err_q, err_d;
  logic accept;
  logic [7:0] c;
  logic [4:0] hv;
  logic [3:0][7:0] oct_f;
  logic v4fin;
  logic [7:0][15:0] head_f, tail_f;
  logic [3:0] headc_f, tailc_f;
  logic err_f;

  assign in_ready_o = snap_ready_i;
  assign accept = in_valid_i && in_ready_o;
  assign c = text_char_i;

  always_comb begin
    hv = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) hv = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) hv = {1'b0, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) hv = {1'b0, 4'(c - 8'h37)};
  end

  always_comb begin
    cnt_d = cnt_q; zone_d = zone_q; colp_d = colp_q; v4v_d = v4v_q;
    dacc_d = dacc_q; dcnt_d = dcnt_q; oct_d = oct_q; oidx_d = oidx_q;
    hacc_d = hacc_q; hcnt_d = hcnt_q; sdot_d = sdot_q; head_d = head_q;
    tail_d = tail_q; headc_d = headc_q; tailc_d = tailc_q; dcol_d = dcol_q;
    crun_d = crun_q; err_d = err_q;
    if (!zone_q) begin
      if (c == 8'h25) begin
        zone_d = 1'b1;
        if (!colp_q) begin
          err_d = 1'b1; v4v_d = 1'b0;
        end
      end else begin
        if (cnt_q <= CntW'(MaxTextLength)) cnt_d = cnt_q + 1'b1;
        if (c == 8'h3a) begin
          colp_d = 1'b1;
          v4v_d = 1'b1; dacc_d = '0; dcnt_d = '0; oidx_d = '0;
          if (!err_q) begin
            if (crun_q == 2'd0) begin
              if (sdot_q) err_d = 1'b1;
              else if (hcnt_q == 3'd0 && (headc_q != 4'd0 || dcol_q)) err_d = 1'b1;
              else begin
                if (hcnt_q != 3'd0) begin
                  if (headc_q + tailc_q >= 4'd8) err_d = 1'b1;
                  else if (!dcol_q) begin
                    head_d[headc_q[2:0]] = hacc_q; headc_d = headc_q + 4'd1;
                  end else begin
                    tail_d[tailc_q[2:0]] = hacc_q; tailc_d = tailc_q + 4'd1;
                  end
                end
                if (!(hcnt_q != 3'd0 && headc_q + tailc_q >= 4'd8)) begin
                  hacc_d = '0; hcnt_d = '0; crun_d = 2'd1;
                end
              end
            end else if (crun_q == 2'd1) begin
              if (dcol_q) err_d = 1'b1;
              else begin
                dcol_d = 1'b1; crun_d = 2'd2;
              end
            end else err_d = 1'b1;
          end
        end else begin
          if (v4v_q) begin
            if (hv[4] == 1'b0 && c <= 8'h39) begin
              if (dcnt_q == 2'd3) v4v_d = 1'b0;
              else begin
                dacc_d = 10'(dacc_q * 10 + 10'(hv[3:0]));
                dcnt_d = dcnt_q + 2'd1;
              end
            end else if (c == 8'h2e) begin
              if (dcnt_q == 2'd0 || dacc_q > 10'd255 || oidx_q == 2'd3) v4v_d = 1'b0;
              else begin
                oct_d[oidx_q] = dacc_q[7:0]; oidx_d = oidx_q + 2'd1;
                dacc_d = '0; dcnt_d = '0;
              end
            end else v4v_d = 1'b0;
          end
          if (!err_q) begin
            if (crun_q == 2'd1 && headc_q == 4'd0 && !dcol_q && colp_q) err_d = 1'b1;
            else begin
              crun_d = 2'd0;
              if (c == 8'h2e) sdot_d = 1'b1;
              else if (hv[4]) err_d = 1'b1;
              else if (!sdot_q) begin
                if (hcnt_q == 3'd4) err_d = 1'b1;
                else begin
                  hacc_d = {hacc_q[11:0], hv[3:0]}; hcnt_d = hcnt_q + 3'd1;
                end
              end
            end
          end
        end
      end
    end
  end

  // finishing logic on the updated state
  always_comb begin
    oct_f = oct_d;
    oct_f[3] = dacc_d[7:0];
    v4fin = v4v_d && dcnt_d != 2'd0 && dacc_d <= 10'd255 && oidx_d == 2'd3;
    head_f = head_d; tail_f = tail_d; headc_f = headc_d; tailc_f = tailc_d;
    err_f = err_d || crun_d == 2'd1 || cnt_d > CntW'(MaxTextLength);
    if (!err_f && crun_d == 2'd0) begin
      if (sdot_d) begin
        if (!v4fin || headc_d + tailc_d >= 4'd7) err_f = 1'b1;
        else if (!dcol_d) begin
          head_f[headc_d[2:0]] = {oct_f[0], oct_f[1]};
          head_f[3'(headc_d + 4'd1)] = {oct_f[2], oct_f[3]};
          headc_f = headc_d + 4'd2;
        end else begin
          tail_f[tailc_d[2:0]] = {oct_f[0], oct_f[1]};
          tail_f[3'(tailc_d + 4'd1)] = {oct_f[2], oct_f[3]};
          tailc_f = tailc_d + 4'd2;
        end
      end else begin
        if (hcnt_d == 3'd0 || headc_d + tailc_d >= 4'd8) err_f = 1'b1;
        else if (!dcol_d) begin
          head_f[headc_d[2:0]] = hacc_d; headc_f = headc_d + 4'd1;
        end else begin
          tail_f[tailc_d[2:0]] = hacc_d; tailc_f = tailc_d + 4'd1;
        end
      end
    end
    if (dcol_d ? (headc_f + tailc_f > 4'd7) : (headc_f + tailc_f != 4'd8)) err_f = 1'b1;
    snap_o.head = head_f;
    snap_o.tail = tail_f;
    snap_o.head_cnt = headc_f;
    snap_o.tail_cnt = tailc_f;
    snap_o.dcolon = dcol_d;
    snap_o.v6_ok = !err_f;
    snap_o.v4_ok = v4fin && !zone_d;
    snap_o.v4_addr = {oct_f[0], oct_f[1], oct_f[2], oct_f[3]};
    snap_o.colon_present = colp_d;
  end

  assign snap_valid_o = in_valid_i && last_char_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; zone_q <= 1'b0; colp_q <= 1'b0; v4v_q <= 1'b1;
      dacc_q <= '0; dcnt_q <= '0; oidx_q <= '0; hacc_q <= '0; hcnt_q <= '0;
      sdot_q <= 1'b0; headc_q <= '0; tailc_q <= '0; dcol_q <= 1'b0;
      crun_q <= '0; err_q <= 1'b0;
    end else if (accept) begin
      if (last_char_i) begin
        cnt_q <= '0; zone_q <= 1'b0; colp_q <= 1'b0; v4v_q <= 1'b1;
        dacc_q <= '0; dcnt_q <= '0; oidx_q <= '0; hacc_q <= '0; hcnt_q <= '0;
        sdot_q <= 1'b0; headc_q <= '0; tailc_q <= '0; dcol_q <= 1'b0;
        crun_q <= '0; err_q <= 1'b0;
      end else begin
        cnt_q <= cnt_d; zone_q <= zone_d; colp_q <= colp_d; v4v_q <= v4v_d;
        dacc_q <= dacc_d; dcnt_q <= dcnt_d; oidx_q <= oidx_d; hacc_q <= hacc_d;
        hcnt_q <= hcnt_d; sdot_q <= sdot_d; headc_q <= headc_d; tailc_q <= tailc_d;
        dcol_q <= dcol_d; crun_q <= crun_d; err_q <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      oct_q <= oct_d; head_q <= head_d; tail_q <= tail_d;
    end
  end
endmodule
`default_nettype wire

// ----- design/ilbc_queue.sv -----
// two-entry fifo of parser snapshots
`timescale 1ns / 1ps
`default_nettype none
module ilbc_queue import ilbc_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   wr_valid_i,
  output logic        wr_ready_o,
  input  wire parse_t wr_data_i,
  output logic        rd_valid_o,
  input  wire logic   rd_ready_i,
  output parse_t      rd_data_o
);
  parse_t mem_q [QDepth];
  logic [$clog2(QDepth)-1:0] wp_q, rp_q;
  logic [$clog2(QDepth+1)-1:0] cnt_q;
  logic wr, rd;

  assign wr_ready_o = cnt_q != ($clog2(QDepth+1))'(QDepth);
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + ($clog2(QDepth+1))'(wr) - ($clog2(QDepth+1))'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end
endmodule
`default_nettype wire

// ----- design/ilbc_back.sv -----
// address assembly, range match and output register
`timescale 1ns / 1ps
`default_nettype none
module ilbc_back import ilbc_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   in_valid_i,
  output logic        in_ready_o,
  input  wire parse_t in_data_i,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output result_t     out_o
);
  result_t res_d, res_q;
  logic valid_q;
  logic [7:0][15:0] g;
  logic [127:0] addr;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < in_data_i.head_cnt) g[i] = in_data_i.head[i];
      else if (4'(i) >= 4'd8 - in_data_i.tail_cnt)
        g[i] = in_data_i.tail[3'(4'(i) - (4'd8 - in_data_i.tail_cnt))];
      else g[i] = '0;
    end
    for (int i = 0; i < 8; i++) addr[127 - 16*i -: 16] = g[i];
    res_d.literal_kind = KIND_NONE;
    res_d.range_code = CodeNotIp;
    res_d.address_high = '0;
    res_d.address_low = '0;
    if (!in_data_i.colon_present) begin
      if (in_data_i.v4_ok) begin
        res_d.literal_kind = KIND_V4;
        res_d.address_low = {32'd0, in_data_i.v4_addr};
        res_d.range_code = match_v4(in_data_i.v4_addr);
      end
    end else if (in_data_i.v6_ok) begin
      res_d.literal_kind = KIND_V6;
      res_d.address_high = addr[127:64];
      res_d.address_low = addr[63:0];
      if (addr[127:64] == 64'd0 && addr[63:32] == 32'h0000ffff)
        res_d.range_code = match_v4(addr[31:0]);
      else res_d.range_code = match_v6(addr[127:64], addr[63:0]);
    end
    res_d.blocked = res_d.range_code != CodeNone;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (in_ready_o) valid_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) res_q <= res_d;
  end

  assign out_valid_o = valid_q;
  assign out_o = res_q;
endmodule
`default_nettype wire

// ----- design/ip_literal_blocklist_classifier.sv -----
// top level of the ip literal blocklist classifier
// one character accepted per cycle while the snapshot queue has room; characters other than the last give no result
// on the last character a parser snapshot is written to the queue, then classified into the output register
// throughput: one character per cycle; input stalls only while the two-entry queue is full
// reset: asynchronous active low, clears parser, queue and output state
`timescale 1ns / 1ps
`default_nettype none
module ip_literal_blocklist_classifier import ilbc_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  ilbc_char_if.sink  in_ch,
  ilbc_res_if.source out_ch
);
  parse_t snap, qd;
  result_t res;
  logic snap_valid, snap_ready, q_valid, q_ready;

  ilbc_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid), .in_ready_o(in_ch.ready),
    .text_char_i(in_ch.text_char), .last_char_i(in_ch.last_char),
    .snap_valid_o(snap_valid), .snap_ready_i(snap_ready), .snap_o(snap)
  );

  ilbc_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(snap_valid), .wr_ready_o(snap_ready), .wr_data_i(snap),
    .rd_valid_o(q_valid), .rd_ready_i(q_ready), .rd_data_o(qd)
  );

  ilbc_back u_back (
    .clk_i, .rst_ni,
    .in_valid_i(q_valid), .in_ready_o(q_ready), .in_data_i(qd),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready), .out_o(res)
  );

  assign out_ch.literal_kind = res.literal_kind;
  assign out_ch.blocked = res.blocked;
  assign out_ch.range_code = res.range_code;
  assign out_ch.address_high = res.address_high;
  assign out_ch.address_low = res.address_low;
endmodule
`default_nettype wire

// ----- design/ilbc_checker.sv -----
// port-level checks for the classifier and their binding
`timescale 1ns / 1ps
`default_nettype none
module ilbc_checker import ilbc_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [1:0]  literal_kind_i,
  input wire logic        blocked_i,
  input wire logic [4:0]  range_code_i,
  input wire logic [63:0] address_high_i
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(range_code_i))
    else $error("result dropped while stalled");
  a_blk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> blocked_i == (range_code_i != CodeNone))
    else $error("blocked flag mismatch");
  a_notip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && literal_kind_i == KIND_NONE |-> range_code_i == CodeNotIp)
    else $error("non literal without not-ip code");
  a_v4hi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && literal_kind_i == KIND_V4 |->
      address_high_i == 64'd0 && range_code_i < CodeV6Base)
    else $error("ipv4 result inconsistent");
endmodule

bind ip_literal_blocklist_classifier ilbc_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid_i(out_ch.valid), .out_ready_i(out_ch.ready),
  .literal_kind_i(out_ch.literal_kind), .blocked_i(out_ch.blocked),
  .range_code_i(out_ch.range_code), .address_high_i(out_ch.address_high)
);
`default_nettype wire

// ----- verif/ip_literal_blocklist_classifier_tb.sv -----
// testbench for the ip literal blocklist classifier: directed and random host texts
`timescale 1ns / 1ps
`default_nettype none
module ip_literal_blocklist_classifier_tb;
  import ilbc_pkg::*;

  logic clk_i;
  logic rst_ni;
  ilbc_char_if in_ch ();
  ilbc_res_if out_ch ();

  ip_literal_blocklist_classifier dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  localparam int unsigned CycleLimit = 400000;

  typedef struct {
    kind_e       kind;
    logic        blocked;
    logic [4:0]  code;
    logic [63:0] hi;
    logic [63:0] lo;
  } verdict_t;

  typedef struct {
    string    text;
    logic     typed;
    verdict_t want;
  } row_t;

  verdict_t verdict_q[$];
  int unsigned errors;
  int unsigned cycles;
  int unsigned results_seen;
  int unsigned texts_sent;
  int unsigned items_sent;
  int unsigned idle_pct_src;
  int unsigned idle_pct_snk;

  // classifier state
  int unsigned n_chars;
  bit in_zone, saw_colon, v4_ok;
  int unsigned dec_acc, dec_cnt, oct_idx;
  logic [7:0] octs [4];
  int unsigned hex_acc, hex_cnt;
  bit seg_dot;
  logic [15:0] heads [8];
  logic [15:0] tails [8];
  int unsigned n_head, n_tail;
  bit dcolon;
  int unsigned colons_in_row;
  bit v6_bad;

  function automatic void parser_clear();
    n_chars = 0; in_zone = 0; saw_colon = 0;
    v4_ok = 1; dec_acc = 0; dec_cnt = 0; oct_idx = 0;
    hex_acc = 0; hex_cnt = 0; seg_dot = 0;
    n_head = 0; n_tail = 0; dcolon = 0; colons_in_row = 0; v6_bad = 0;
    for (int i = 0; i < 8; i++) begin
      heads[i] = '0;
      tails[i] = '0;
    end
    for (int i = 0; i < 4; i++) octs[i] = '0;
  endfunction

  function automatic logic [4:0] v4_range_code(logic [31:0] a);
    logic [31:0] bases [9];
    int unsigned lens [9];
    logic [31:0] m;
    bases = '{32'h0, 32'h0A000000, 32'h64400000, 32'h7F000000, 32'hA9FE0000,
              32'hAC100000, 32'hC0A80000, 32'hE0000000, 32'hF0000000};
    lens = '{8, 8, 10, 8, 16, 12, 16, 4, 4};
    for (int i = 0; i < 9; i++) begin
      m = 32'hFFFFFFFF << (32 - lens[i]);
      if ((a & m) == (bases[i] & m)) return 5'(i + 1);
    end
    return CodeNone;
  endfunction

  function automatic logic [4:0] v6_range_code(logic [127:0] a);
    logic [127:0] bases [6];
    int unsigned lens [6];
    logic [127:0] m;
    bases = '{128'h0, 128'h1, {64'h0064ff9b00000000, 64'h0},
              {64'h2002000000000000, 64'h0}, {64'hfc00000000000000, 64'h0},
              {64'hfe80000000000000, 64'h0}};
    lens = '{128, 128, 96, 16, 7, 10};
    for (int i = 0; i < 6; i++) begin
      m = ~128'h0 << (128 - lens[i]);
      if ((a & m) == (bases[i] & m)) return CodeV6Base + 5'(i);
    end
    return CodeNone;
  endfunction

  function automatic void dec_char(int unsigned c);
    if (!v4_ok) return;
    if (c >= "0" && c <= "9") begin
      if (dec_cnt >= 3) begin
        v4_ok = 0;
        return;
      end
      dec_acc = dec_acc * 10 + (c - "0");
      dec_cnt++;
    end else if (c == ".") begin
      if (dec_cnt == 0 || dec_acc > 255 || oct_idx >= 3) begin
        v4_ok = 0;
        return;
      end
      octs[oct_idx] = dec_acc[7:0];
      oct_idx++;
      dec_acc = 0;
      dec_cnt = 0;
    end else begin
      v4_ok = 0;
    end
  endfunction

  function automatic bit dec_done();
    if (!v4_ok || dec_cnt == 0 || dec_acc > 255 || oct_idx != 3) return 0;
    octs[3] = dec_acc[7:0];
    return 1;
  endfunction

  function automatic void add_group(int unsigned g);
    if (n_head + n_tail >= 8) begin
      v6_bad = 1;
      return;
    end
    if (!dcolon) heads[n_head++] = g[15:0];
    else tails[n_tail++] = g[15:0];
  endfunction

  function automatic void colon_char();
    if (colons_in_row == 0) begin
      if (seg_dot) begin
        v6_bad = 1;
        return;
      end
      if (hex_cnt == 0) begin
        if (n_head != 0 || dcolon) begin
          v6_bad = 1;
          return;
        end
      end else begin
        add_group(hex_acc);
      end
      hex_acc = 0; hex_cnt = 0; colons_in_row = 1;
    end else if (colons_in_row == 1) begin
      if (dcolon) begin
        v6_bad = 1;
        return;
      end
      dcolon = 1; colons_in_row = 2;
    end else begin
      v6_bad = 1;
    end
  endfunction

  function automatic void hex_char(int unsigned c);
    int v;
    if (colons_in_row == 1 && n_head == 0 && !dcolon && saw_colon) begin
      v6_bad = 1;
      return;
    end
    colons_in_row = 0;
    if (c == ".") begin
      seg_dot = 1;
      return;
    end
    if (c >= "0" && c <= "9") v = c - "0";
    else if (c >= "a" && c <= "f") v = c - "a" + 10;
    else if (c >= "A" && c <= "F") v = c - "A" + 10;
    else v = -1;
    if (v < 0) begin
      v6_bad = 1;
      return;
    end
    if (seg_dot) return;
    if (hex_cnt >= 4) begin
      v6_bad = 1;
      return;
    end
    hex_acc = ((hex_acc << 4) | v) & 16'hffff;
    hex_cnt++;
  endfunction

  function automatic bit v6_done(output logic [127:0] a);
    int unsigned g;
    a = '0;
    if (v6_bad || colons_in_row == 1 || n_chars > MaxTextLength) return 0;
    if (colons_in_row == 0) begin
      if (seg_dot) begin
        if (!dec_done()) return 0;
        add_group({octs[0], octs[1]});
        add_group({octs[2], octs[3]});
      end else begin
        if (hex_cnt == 0) return 0;
        add_group(hex_acc);
      end
      if (v6_bad) return 0;
    end
    if (dcolon ? (n_head + n_tail > 7) : (n_head + n_tail != 8)) return 0;
    for (int i = 0; i < 8; i++) begin
      if (i < n_head) g = heads[i];
      else if (i >= 8 - n_tail) g = tails[i - (8 - n_tail)];
      else g = 0;
      a = (a << 16) | g;
    end
    return 1;
  endfunction

  // returns 1 when the character closes a text
  function automatic bit classify_char(logic [7:0] c, logic last, output verdict_t v);
    logic [127:0] a6;
    v = '{KIND_NONE, 1'b1, CodeNotIp, 64'h0, 64'h0};
    if (!in_zone) begin
      if (c == "%") begin
        in_zone = 1;
        if (!saw_colon) begin
          v6_bad = 1;
          v4_ok = 0;
        end
      end else begin
        if (n_chars <= MaxTextLength) n_chars++;
        if (c == ":") begin
          saw_colon = 1;
          if (!v6_bad) colon_char();
          v4_ok = 1; dec_acc = 0; dec_cnt = 0; oct_idx = 0;
        end else begin
          dec_char(c);
          if (!v6_bad) hex_char(c);
        end
      end
    end
    if (!last) return 0;
    if (!saw_colon) begin
      if (!in_zone && dec_done()) begin
        v.kind = KIND_V4;
        v.lo = {32'h0, octs[0], octs[1], octs[2], octs[3]};
        v.code = v4_range_code(v.lo[31:0]);
      end
    end else if (v6_done(a6)) begin
      v.kind = KIND_V6;
      v.hi = a6[127:64];
      v.lo = a6[63:0];
      if (v.hi == 0 && v.lo[63:32] == 32'hffff) v.code = v4_range_code(v.lo[31:0]);
      else v.code = v6_range_code(a6);
    end
    v.blocked = (v.code != CodeNone);
    parser_clear();
    return 1;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
  endtask

  task automatic send_char(logic [7:0] c, logic last);
    verdict_t v;
    if (idle_pct_src != 0) begin
      while ($urandom_range(99) < idle_pct_src) begin
        in_ch.valid <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.text_char <= c;
    in_ch.last_char <= last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    items_sent++;
    if (classify_char(c, last, v)) verdict_q.insert(verdict_q.size(), v);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (verdict_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic send_text(string s, bit typed, verdict_t want);
    verdict_t got;
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    texts_sent++;
    if (typed) begin
      got = verdict_q[$];
      if (got.kind != want.kind || got.code != want.code || got.lo != want.lo ||
          got.hi != want.hi)
        report_mismatch({"typed row ", s}, {got.kind, got.code}, {want.kind, want.code});
    end
  endtask

  function automatic string hex4(int unsigned v);
    return $sformatf("%0h", v[15:0]);
  endfunction

  function automatic string dec_octets(bit wild);
    string s;
    s = "";
    for (int i = 0; i < 4; i++) begin
      if (i) s = {s, "."};
      if (wild && $urandom_range(9) == 0) s = {s, $sformatf("%0d", $urandom_range(999))};
      else s = {s, $sformatf("%0d", $urandom_range(3) == 0 ?
                 {$urandom_range(1) ? 8'd0 : 8'd255} : $urandom_range(255))};
    end
    return s;
  endfunction

  function automatic string rand_v6();
    string s;
    int unsigned n, gap;
    bit v4tail;
    s = "";
    v4tail = ($urandom_range(4) == 0);
    n = v4tail ? 6 : 8;
    gap = $urandom_range(2) == 0 ? 99 : $urandom_range(n - 1);
    for (int i = 0; i < n; i++) begin
      if (i == gap) begin
        s = {s, "::"};
        i += $urandom_range(2);
        continue;
      end
      if (i != 0 && !(i - 1 == gap) && s.len() != 0) s = {s, ":"};
      case ($urandom_range(5))
        0: s = {s, "0"};
        1: s = {s, "ffff"};
        2: s = {s, "FE80"};
        default: s = {s, hex4($urandom)};
      endcase
    end
    if (v4tail) begin
      if (s.len() != 0 && s[s.len() - 1] != ":") s = {s, ":"};
      s = {s, dec_octets(0)};
    end
    if ($urandom_range(7) == 0) s = {s, "%eth", $sformatf("%0d", $urandom_range(9))};
    return s;
  endfunction

  function automatic string mutate(string s);
    int unsigned p;
    string t;
    t = s;
    if (t.len() == 0) return "x";
    p = $urandom_range(t.len() - 1);
    case ($urandom_range(2))
      0: t[p] = 8'($urandom);
      1: t = {t.substr(0, p), t.substr(p, t.len() - 1)};
      default: t = {t, ":"};
    endcase
    return t;
  endfunction

  row_t rows [$];
  verdict_t none_v;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result checker and sink stall
  always @(posedge clk_i) begin
    verdict_t w;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (verdict_q.size() == 0) begin
        report_mismatch("unexpected result", out_ch.range_code, 0);
      end else begin
        w = verdict_q.pop_front();
        if (out_ch.literal_kind != w.kind)
          report_mismatch("literal_kind", out_ch.literal_kind, w.kind);
        if (out_ch.blocked != w.blocked) report_mismatch("blocked", out_ch.blocked, w.blocked);
        if (out_ch.range_code != w.code) report_mismatch("range_code", out_ch.range_code, w.code);
        if (out_ch.address_high != w.hi) report_mismatch("address_high", out_ch.address_high, w.hi);
        if (out_ch.address_low != w.lo) report_mismatch("address_low", out_ch.address_low, w.lo);
      end
    end
  end

  always @(negedge clk_i) begin
    out_ch.ready <= (idle_pct_snk == 0) || ($urandom_range(99) >= idle_pct_snk);
  end

  initial begin
    string s;
    errors = 0; cycles = 0; results_seen = 0; texts_sent = 0; items_sent = 0;
    idle_pct_src = 34; idle_pct_snk = 34;
    in_ch.valid = 1'b0; in_ch.text_char = '0; in_ch.last_char = 1'b0;
    out_ch.ready = 1'b0;
    none_v = '{KIND_NONE, 1'b1, CodeNotIp, 64'h0, 64'h0};
    parser_clear();
    rows = '{
      '{"0.0.0.0", 1, '{KIND_V4, 1'b1, 5'd1, 64'h0, 64'h0}},
      '{"255.255.255.255", 1, '{KIND_V4, 1'b1, 5'd9, 64'h0, 64'hffffffff}},
      '{"8.8.8.8", 1, '{KIND_V4, 1'b0, CodeNone, 64'h0, 64'h08080808}},
      '{"256.1.1.1", 1, none_v},
      '{"1.2.3", 1, none_v},
      '{"0001.2.3.4", 1, none_v},
      '{"10.1.2.3%x", 1, none_v},
      '{"::", 1, '{KIND_V6, 1'b1, 5'd10, 64'h0, 64'h0}},
      '{"::1", 1, '{KIND_V6, 1'b1, 5'd11, 64'h0, 64'h1}},
      '{"::ffff:192.168.1.1", 0, none_v},
      '{"64:ff9b::1.2.3.4", 0, none_v},
      '{"2002::1", 0, none_v},
      '{"fc00::", 0, none_v},
      '{"FE80::1%eth0", 0, none_v},
      '{"1:2:3:4:5:6:7:8", 0, none_v},
      '{"1:2:3:4:5:6:7:8::", 1, none_v},
      '{"1::2:3:4:5:6:7:8", 1, none_v},
      '{":1::2", 1, none_v},
      '{"1:::2", 1, none_v},
      '{"12345::", 1, none_v},
      '{"1111:2222:3333:4444:5555:6666:7777:8888:0", 1, none_v},
      '{"0000:0000:0000:0000:0000:0000:0000:0000:000", 1, none_v},
      '{"1:2:3:4:5:6:1.2.3.4", 0, none_v},
      '{"g", 1, none_v},
      '{"::1%\377\200", 0, none_v}
    };
    @(posedge rst_ni);
    @(negedge clk_i);
    foreach (rows[i]) send_text(rows[i].text, rows[i].typed, rows[i].want);
    // one-byte texts with every bit pattern, covering the full range of bytes
    for (int b = 0; b < 256; b++) begin
      s = "1";
      s[0] = 8'(b);
      send_text(s, 0, none_v);
    end
    // hold off until the queue has drained
    drain_results();
    while (items_sent < 1750) begin
      if (texts_sent % 150 < 25) begin
        idle_pct_src = 0;
        idle_pct_snk = 0;
      end else begin
        idle_pct_src = 34;
        idle_pct_snk = 34;
      end
      case ($urandom_range(9))
        0, 1, 2: s = dec_octets(1);
        3, 4, 5, 6: s = rand_v6();
        7: s = mutate(rand_v6());
        8: s = mutate(dec_octets(0));
        default: begin
          s = "";
          repeat ($urandom_range(1, 50)) s = {s, string'(8'($urandom_range(255) | 1))};
        end
      endcase
      if (s.len() == 0) s = "0";
      send_text(s, 0, none_v);
    end
    drain_results();
    repeat (10) @(negedge clk_i);
    $display("covered %0d host texts, %0d characters, %0d results checked",
             texts_sent, items_sent, results_seen);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire
